FILE: design/lbag_pkg.sv
// package for the light bar axis geometry pipeline
// constants, cordic angle table and small helpers; no dependencies
package lbag_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int SQ_STEPS     = 18;
    localparam int HALF_TURN    = 46080;
    localparam int QUARTER_TURN = 23040;
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

    // side payload widths carried beside the two cordic lanes
    localparam int ROT_PAY_W = 65; // cx, cy, w, h, fold flag
    localparam int VEC_PAY_W = 73; // endpoints, flat flag

    // sine/cosine cordic lane: x, y in q1.30, z in 1/65536 degree
    typedef struct packed {
        logic signed [33:0] x;
        logic signed [33:0] y;
        logic signed [24:0] z;
    } t_rot;

    // vectoring cordic lane
    typedef struct packed {
        logic signed [37:0] x;
        logic signed [37:0] y;
        logic signed [25:0] z;
    } t_vec;

    function automatic logic signed [24:0] atan_tab(input logic [3:0] i);
        case (i)
            4'd0:  atan_tab = 25'sd2949120;
            4'd1:  atan_tab = 25'sd1740967;
            4'd2:  atan_tab = 25'sd919879;
            4'd3:  atan_tab = 25'sd466945;
            4'd4:  atan_tab = 25'sd234379;
            4'd5:  atan_tab = 25'sd117304;
            4'd6:  atan_tab = 25'sd58666;
            4'd7:  atan_tab = 25'sd29335;
            4'd8:  atan_tab = 25'sd14668;
            4'd9:  atan_tab = 25'sd7334;
            4'd10: atan_tab = 25'sd3667;
            4'd11: atan_tab = 25'sd1833;
            4'd12: atan_tab = 25'sd917;
            4'd13: atan_tab = 25'sd458;
            4'd14: atan_tab = 25'sd229;
            4'd15: atan_tab = 25'sd115;
            default: atan_tab = 25'sd0;
        endcase
    endfunction

endpackage

FILE: design/light_bar_axis_geometry.sv
// light bar axis geometry: rotated box to endpoints, lengths and tilt
// top level; uses lbag_pkg, lbag_rot_stage, lbag_vec_stage, lbag_sqrt_stage
//
// usage
//   slave channel s_axis_*: one beat per box, tdata holds center_x, center_y,
//   box_w, box_h (unsigned q12.4) and box_angle (signed, 1/256 degree)
//   master channel m_axis_*: one beat per box, tdata holds top_x, top_y,
//   bottom_x, bottom_y (signed q14.4), bar_length, bar_width, tilt
//   throughput: one beat per cycle, sustained while the receiver is ready
//   pipeline: 39 register stages: 16 sine/cosine cordic steps, q16
//   rounding, multiply, offsets and squares, sums of squares, 18 square
//   root steps (16 vectoring cordic steps plus two delay stages beside
//   them) and the output register
//   the whole pipeline advances as one; it holds when the output register
//   is full and the receiver stalls, so nothing is lost or repeated
//   s_axis_tready = !m_axis_tvalid || m_axis_tready
//   reset clears every valid bit; payload registers carry no reset
module light_bar_axis_geometry import lbag_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // center_x[15:0] center_y[31:16] box_w[47:32] box_h[63:48] box_angle[79:64]
    input  logic [79:0]  s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // top_x[17:0] top_y[35:18] bottom_x[53:36] bottom_y[71:54]
    // bar_length[87:72] bar_width[103:88] tilt[118:104], zero fill to 120
    output logic [119:0] m_axis_tdata
);
    logic en;
    assign en = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    // ---------------- front end: fold angle into +-90 degrees
    logic signed [16:0] a_in;
    logic signed [16:0] a_fold;
    logic neg_in;
    t_rot lane0;
    always_comb begin
        a_in   = 17'(signed'(s_axis_tdata[79:64]));
        neg_in = 1'b0;
        a_fold = a_in;
        if (a_in > 17'sd23040) begin
            a_fold = a_in - 17'sd46080;
            neg_in = 1'b1;
        end else if (a_in < -17'sd23040) begin
            a_fold = a_in + 17'sd46080;
            neg_in = 1'b1;
        end
        lane0.x = CORDIC_GAIN;
        lane0.y = '0;
        lane0.z = {a_fold, 8'd0};
    end

    logic                 rv [0:CORDIC_STEPS];
    t_rot                 rl [0:CORDIC_STEPS];
    logic [ROT_PAY_W-1:0] rp [0:CORDIC_STEPS];
    assign rv[0] = s_axis_tvalid;
    assign rl[0] = lane0;
    assign rp[0] = {neg_in, s_axis_tdata[63:0]};

    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_rot
        lbag_rot_stage u_rot (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_step(4'(g)),
            .i_valid(rv[g]), .i_lane(rl[g]), .i_pay(rp[g]),
            .o_valid(rv[g+1]), .o_lane(rl[g+1]), .o_pay(rp[g+1])
        );
    end

    // ---------------- round sin/cos to q16 and clamp
    function automatic logic signed [17:0] q16(input logic signed [33:0] v, input logic ng);
        logic signed [34:0] s;
        logic signed [34:0] t;
        s = ng ? -35'(v) : 35'(v);
        t = (s + 35'sd8192) >>> 14;
        if (t > 35'sd65536)       q16 = 18'sd65536;
        else if (t < -35'sd65536) q16 = -18'sd65536;
        else                      q16 = t[17:0];
    endfunction

    logic r1_valid;
    logic signed [17:0] r1_sn, r1_cs;
    logic [63:0] r1_box;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r1_valid <= 1'b0;
        else if (en)  r1_valid <= rv[CORDIC_STEPS];
        if (en) begin
            r1_sn  <= q16(rl[CORDIC_STEPS].y, rp[CORDIC_STEPS][64]);
            r1_cs  <= q16(rl[CORDIC_STEPS].x, rp[CORDIC_STEPS][64]);
            r1_box <= rp[CORDIC_STEPS][63:0];
        end
    end

    // ---------------- four 17x18 products
    logic r2_valid;
    logic signed [34:0] r2_ws, r2_hc, r2_wc, r2_hs;
    logic [31:0] r2_c;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r2_valid <= 1'b0;
        else if (en)  r2_valid <= r1_valid;
        if (en) begin
            r2_ws <= signed'({1'b0, r1_box[47:32]}) * r1_sn;
            r2_hc <= signed'({1'b0, r1_box[63:48]}) * r1_cs;
            r2_wc <= signed'({1'b0, r1_box[47:32]}) * r1_cs;
            r2_hs <= signed'({1'b0, r1_box[63:48]}) * r1_sn;
            r2_c  <= r1_box[31:0];
        end
    end

    // ---------------- offsets, endpoints, squared lengths
    function automatic logic signed [17:0] rs17(input logic signed [34:0] v);
        logic signed [35:0] t;
        t = (36'(v) + 36'sd65536) >>> 17;
        rs17 = t[17:0];
    endfunction
    function automatic logic signed [17:0] sat_pt(input logic signed [19:0] v);
        if (v > 20'sd131071)      sat_pt = 18'sd131071;
        else if (v < -20'sd65536) sat_pt = -18'sd65536;
        else                      sat_pt = v[17:0];
    endfunction
    function automatic logic [35:0] sq(input logic signed [17:0] v);
        logic signed [18:0] d;
        logic [17:0] m;
        d = 19'(v) <<< 1;
        m = d[18] ? 18'(-d) : d[17:0];
        sq = 36'(m) * 36'(m);
    endfunction

    logic signed [17:0] dxs, dyc, dxc, dys;
    logic signed [19:0] mx, my, px, py, cxe, cye;
    assign dxs = rs17(r2_ws);
    assign dyc = rs17(r2_hc);
    assign dxc = rs17(r2_wc);
    assign dys = rs17(r2_hs);
    assign cxe = 20'({4'd0, r2_c[15:0]});
    assign cye = 20'({4'd0, r2_c[31:16]});
    assign mx = cxe - 20'(dxs);
    assign my = cye + 20'(dyc);
    assign px = cxe + 20'(dxs);
    assign py = cye - 20'(dyc);

    logic r3_valid;
    logic [71:0] r3_pts;
    logic r3_flat;
    logic [16:0] r3_ax, r3_ay;
    logic [35:0] r3_dx2, r3_dy2, r3_wx2, r3_wy2;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r3_valid <= 1'b0;
        else if (en)  r3_valid <= r2_valid;
        if (en) begin
            if (py < my) r3_pts <= {sat_pt(my), sat_pt(mx), sat_pt(py), sat_pt(px)};
            else         r3_pts <= {sat_pt(py), sat_pt(px), sat_pt(my), sat_pt(mx)};
            r3_flat <= (dyc == 18'sd0);
            r3_ax   <= dxs[17] ? 17'(-dxs) : dxs[16:0];
            r3_ay   <= dyc[17] ? 17'(-dyc) : dyc[16:0];
            r3_dx2  <= sq(dxs);
            r3_dy2  <= sq(dyc);
            r3_wx2  <= sq(dxc);
            r3_wy2  <= sq(dys);
        end
    end

    // ---------------- sums of squares
    logic r4_valid;
    logic [71:0] r4_pts;
    logic r4_flat;
    logic [16:0] r4_ax, r4_ay;
    logic [36:0] r4_ls, r4_ws;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r4_valid <= 1'b0;
        else if (en)  r4_valid <= r3_valid;
        if (en) begin
            r4_pts  <= r3_pts;
            r4_flat <= r3_flat;
            r4_ax   <= r3_ax;
            r4_ay   <= r3_ay;
            r4_ls   <= 37'(r3_dx2) + 37'(r3_dy2);
            r4_ws   <= 37'(r3_wx2) + 37'(r3_wy2);
        end
    end

    // ---------------- vectoring cordic for tilt, two square roots beside it
    // sums above 36 bits already saturate, so they pin the radicand high
    t_vec vl0;
    assign vl0.x = 38'(r4_ay) <<< 15;
    assign vl0.y = 38'(r4_ax) <<< 15;
    assign vl0.z = '0;

    logic                 vv [0:CORDIC_STEPS];
    t_vec                 vl [0:CORDIC_STEPS];
    logic [VEC_PAY_W-1:0] vp [0:CORDIC_STEPS];
    assign vv[0] = r4_valid;
    assign vl[0] = vl0;
    assign vp[0] = {r4_flat, r4_pts};
    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_vec
        lbag_vec_stage u_vec (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_step(4'(g)),
            .i_valid(vv[g]), .i_lane(vl[g]), .i_pay(vp[g]),
            .o_valid(vv[g+1]), .o_lane(vl[g+1]), .o_pay(vp[g+1])
        );
    end

    logic [35:0] la [0:SQ_STEPS], lr [0:SQ_STEPS], wa [0:SQ_STEPS], wr [0:SQ_STEPS];
    logic [17:0] lq [0:SQ_STEPS], wq [0:SQ_STEPS];
    logic        lv [0:SQ_STEPS], wv [0:SQ_STEPS];
    assign la[0] = r4_ls[36] ? '1 : r4_ls[35:0];
    assign wa[0] = r4_ws[36] ? '1 : r4_ws[35:0];
    assign lr[0] = '0; assign wr[0] = '0;
    assign lq[0] = '0; assign wq[0] = '0;
    assign lv[0] = r4_valid; assign wv[0] = r4_valid;
    for (genvar g = 0; g < SQ_STEPS; g++) begin : g_sq
        lbag_sqrt_stage u_len (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(lv[g]),
            .i_rad(la[g]), .i_rem(lr[g]), .i_root(lq[g]),
            .o_valid(lv[g+1]), .o_rad(la[g+1]), .o_rem(lr[g+1]),
            .o_root(lq[g+1])
        );
        lbag_sqrt_stage u_wid (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(wv[g]),
            .i_rad(wa[g]), .i_rem(wr[g]), .i_root(wq[g]),
            .o_valid(wv[g+1]), .o_rad(wa[g+1]), .o_rem(wr[g+1]),
            .o_root(wq[g+1])
        );
    end

    // two extra stages align the cordic (16) with the square root (18)
    logic r5_valid, r6_valid;
    logic [VEC_PAY_W-1:0] r5_pay, r6_pay;
    logic signed [25:0] r5_z, r6_z;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_valid <= 1'b0;
            r6_valid <= 1'b0;
        end else if (en) begin
            r5_valid <= vv[CORDIC_STEPS];
            r6_valid <= r5_valid;
        end
        if (en) begin
            r5_pay <= vp[CORDIC_STEPS];
            r5_z   <= vl[CORDIC_STEPS].z;
            r6_pay <= r5_pay;
            r6_z   <= r5_z;
        end
    end

    // ---------------- output register
    function automatic logic [15:0] sqrt_fin(input logic [17:0] q, input logic [35:0] rm);
        logic [18:0] r;
        r = 19'(q) + ((rm > 36'(q)) ? 19'd1 : 19'd0);
        sqrt_fin = (r > 19'd65535) ? 16'hffff : r[15:0];
    endfunction
    logic signed [25:0] tz;
    logic [14:0] tilt_v;
    always_comb begin
        tz = (r6_z + 26'sd128) >>> 8;
        if (r6_pay[72])                tilt_v = 15'd23040;
        else if (tz < 26'sd0)          tilt_v = 15'd0;
        else if (tz > 26'sd23040)      tilt_v = 15'd23040;
        else                           tilt_v = tz[14:0];
    end

    logic r_valid;
    logic [119:0] r_data;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_valid <= 1'b0;
        else if (en)  r_valid <= r6_valid;
        if (en) begin
            r_data <= {1'b0, tilt_v, sqrt_fin(wq[SQ_STEPS], wr[SQ_STEPS]),
                       sqrt_fin(lq[SQ_STEPS], lr[SQ_STEPS]), r6_pay[71:0]};
        end
    end

    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata  = r_data;
endmodule

FILE: design/lbag_rot_stage.sv
// one registered sine/cosine cordic micro-rotation with its side payload
// uses lbag_pkg
module lbag_rot_stage import lbag_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic [3:0]           i_step,
    input  logic                 i_valid,
    input  t_rot                 i_lane,
    input  logic [ROT_PAY_W-1:0] i_pay,
    output logic                 o_valid,
    output t_rot                 o_lane,
    output logic [ROT_PAY_W-1:0] o_pay
);
    t_rot n_lane;
    t_rot r_lane;
    logic [ROT_PAY_W-1:0] r_pay;
    logic r_valid;

    // i_step is tied to a constant, so the shifts reduce to wiring
    always_comb begin
        n_lane = i_lane;
        if (!i_lane.z[24]) begin
            n_lane.x = i_lane.x - (i_lane.y >>> i_step);
            n_lane.y = i_lane.y + (i_lane.x >>> i_step);
            n_lane.z = i_lane.z - atan_tab(i_step);
        end else begin
            n_lane.x = i_lane.x + (i_lane.y >>> i_step);
            n_lane.y = i_lane.y - (i_lane.x >>> i_step);
            n_lane.z = i_lane.z + atan_tab(i_step);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_lane <= n_lane;
            r_pay  <= i_pay;
        end
    end

    assign o_valid = r_valid;
    assign o_lane  = r_lane;
    assign o_pay   = r_pay;
endmodule

FILE: design/lbag_vec_stage.sv
// one registered vectoring cordic micro-rotation with its side payload
// uses lbag_pkg
module lbag_vec_stage import lbag_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic [3:0]           i_step,
    input  logic                 i_valid,
    input  t_vec                 i_lane,
    input  logic [VEC_PAY_W-1:0] i_pay,
    output logic                 o_valid,
    output t_vec                 o_lane,
    output logic [VEC_PAY_W-1:0] o_pay
);
    t_vec n_lane;
    t_vec r_lane;
    logic [VEC_PAY_W-1:0] r_pay;
    logic r_valid;

    // i_step is tied to a constant, so the shifts reduce to wiring
    always_comb begin
        n_lane = i_lane;
        if (i_lane.y > 0) begin
            n_lane.x = i_lane.x + (i_lane.y >>> i_step);
            n_lane.y = i_lane.y - (i_lane.x >>> i_step);
            n_lane.z = i_lane.z + 26'(atan_tab(i_step));
        end else begin
            n_lane.x = i_lane.x - (i_lane.y >>> i_step);
            n_lane.y = i_lane.y + (i_lane.x >>> i_step);
            n_lane.z = i_lane.z - 26'(atan_tab(i_step));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_lane <= n_lane;
            r_pay  <= i_pay;
        end
    end

    assign o_valid = r_valid;
    assign o_lane  = r_lane;
    assign o_pay   = r_pay;
endmodule

FILE: design/lbag_sqrt_stage.sv
// one registered restoring square root step, two radicand bits per stage
// uses lbag_pkg
module lbag_sqrt_stage import lbag_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [35:0]   i_rad,
    input  logic [35:0]   i_rem,
    input  logic [17:0]   i_root,
    output logic          o_valid,
    output logic [35:0]   o_rad,
    output logic [35:0]   o_rem,
    output logic [17:0]   o_root
);
    logic [37:0] n_trial;
    logic [37:0] n_rem_sh;
    logic [35:0] n_rem;
    logic [17:0] n_root;
    logic [35:0] r_rad, r_rem;
    logic [17:0] r_root;
    logic r_valid;

    // radicand bits are consumed msb-first, two per step
    always_comb begin
        n_rem_sh = {i_rem, i_rad[35:34]};
        n_trial  = {18'd0, i_root, 2'b01};
        if (n_rem_sh >= n_trial) begin
            n_rem  = 36'(n_rem_sh - n_trial);
            n_root = {i_root[16:0], 1'b1};
        end else begin
            n_rem  = n_rem_sh[35:0];
            n_root = {i_root[16:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_rad  <= {i_rad[33:0], 2'b00};
            r_rem  <= n_rem;
            r_root <= n_root;
        end
    end

    assign o_valid = r_valid;
    assign o_rad   = r_rad;
    assign o_rem   = r_rem;
    assign o_root  = r_root;
endmodule

FILE: bench/tb_top.sv
// testbench for light_bar_axis_geometry: directed table then random boxes,
// each output beat checked field by field against an in-bench predictor or, for two directed rows, fixed values
// depends on design/lbag_pkg.sv and design/light_bar_axis_geometry.sv
`timescale 1ns / 100ps

module tb_top import lbag_pkg::*; ();

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 60;
    localparam int RANDOM_BOXES   = 1450;

    typedef struct packed {
        logic [15:0] cx;
        logic [15:0] cy;
        logic [15:0] w;
        logic [15:0] h;
        logic signed [15:0] ang;
    } t_box;

    typedef struct packed {
        logic signed [17:0] top_x;
        logic signed [17:0] top_y;
        logic signed [17:0] bot_x;
        logic signed [17:0] bot_y;
        logic [15:0] len;
        logic [15:0] wid;
        logic [14:0] tilt;
    } t_geom;

    typedef struct {
        t_box  box;
        bit    has_exp;
        t_geom exp_geom;
    } t_row;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [79:0]  s_axis_tdata;   // center_x, center_y, box_w, box_h, box_angle
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [119:0] m_axis_tdata;   // top_x, top_y, bottom_x, bottom_y, length, width, tilt

    light_bar_axis_geometry dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    t_geom pending_geom[$];
    int    mismatches = 0;
    int    idle_cycles = 0;
    bit    timed_out = 0;
    bit    no_idle = 0;    // long stretch with both sides always busy

    always begin
        i_clk = 1'b1; #10;
        i_clk = 1'b0; #10;
    end

    function automatic longint sra(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint rnd_shift(longint v, int s);
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint atan_step(int i);
        return longint'(atan_tab(4'(i)));
    endfunction

    // rotation-mode cordic, angle folded into +-90 degrees
    task automatic sine_cosine(input longint a, output longint sn, output longint cs);
        longint x, y, z, t;
        bit flip;
        x = longint'(CORDIC_GAIN); y = 0; flip = 0;
        if (a > QUARTER_TURN) begin
            a -= HALF_TURN; flip = 1;
        end else if (a < -QUARTER_TURN) begin
            a += HALF_TURN; flip = 1;
        end
        z = a * 256;
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            if (z >= 0) begin
                t = x - sra(y, i); y = y + sra(x, i); z -= atan_step(i);
            end else begin
                t = x + sra(y, i); y = y - sra(x, i); z += atan_step(i);
            end
            x = t;
        end
        if (flip) begin
            x = -x; y = -y;
        end
        cs = clip(rnd_shift(x, 14), -65536, 65536);
        sn = clip(rnd_shift(y, 14), -65536, 65536);
    endtask

    // integer square root rounded to nearest, clamped to 16 bits
    function automatic longint hypot16(longint dx, longint dy);
        longint unsigned v, r, b, rem;
        v = longint'(dx * dx) + longint'(dy * dy);
        r = 0; b = 64'd1 << 62; rem = v;
        while (b > rem) b >>= 2;
        while (b != 0) begin
            if (rem >= r + b) begin
                rem -= r + b; r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        if (rem > r) r++;
        return r > 65535 ? 65535 : longint'(r);
    endfunction

    // vectoring cordic: atan(ax/ay) in 1/256 degree
    function automatic longint bar_tilt(longint ax, longint ay);
        longint x, y, z, t;
        x = ay * 16384; y = ax * 16384; z = 0;
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            if (y > 0) begin
                t = x + sra(y, i); y = y - sra(x, i); z += atan_step(i);
            end else begin
                t = x - sra(y, i); y = y + sra(x, i); z -= atan_step(i);
            end
            x = t;
        end
        return clip((z + 128) >>> 8, 0, QUARTER_TURN);
    endfunction

    task automatic predict_geometry(input t_box b, output t_geom g);
        longint sn, cs, dxs, dyc, dxc, dys, mx, my, px, py, tx, ty, bx, by, tl;
        sine_cosine(longint'(b.ang), sn, cs);
        dxs = rnd_shift(longint'(b.w) * sn, 17);
        dyc = rnd_shift(longint'(b.h) * cs, 17);
        dxc = rnd_shift(longint'(b.w) * cs, 17);
        dys = rnd_shift(longint'(b.h) * sn, 17);
        mx = longint'(b.cx) - dxs; my = longint'(b.cy) + dyc;
        px = longint'(b.cx) + dxs; py = longint'(b.cy) - dyc;
        // minus point wins on equal y
        if (py < my) begin
            tx = px; ty = py; bx = mx; by = my;
        end else begin
            tx = mx; ty = my; bx = px; by = py;
        end
        if (dyc == 0) tl = QUARTER_TURN;
        else tl = bar_tilt(dxs < 0 ? -2 * dxs : 2 * dxs, dyc < 0 ? -2 * dyc : 2 * dyc);
        g.top_x = 18'(clip(tx, -65536, 131071));
        g.top_y = 18'(clip(ty, -65536, 131071));
        g.bot_x = 18'(clip(bx, -65536, 131071));
        g.bot_y = 18'(clip(by, -65536, 131071));
        g.len   = 16'(hypot16(2 * dxs, 2 * dyc));
        g.wid   = 16'(hypot16(2 * dxc, 2 * dys));
        g.tilt  = 15'(tl);
    endtask

    function automatic t_geom unpack_geom(logic [119:0] d);
        t_geom g;
        g.top_x = d[17:0];   g.top_y = d[35:18];
        g.bot_x = d[53:36];  g.bot_y = d[71:54];
        g.len   = d[87:72];  g.wid   = d[103:88];
        g.tilt  = d[118:104];
        return g;
    endfunction

    function automatic bit do_idle();
        return !no_idle && ($urandom_range(99) < 9);
    endfunction

    task automatic report(string what, longint e, longint a);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t mismatch %s: expected %0d got %0d", $realtime, what, e, a);
    endtask

    // output side: random back-pressure, compare at the rising edge
    always @(posedge i_clk) begin
        t_geom got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = unpack_geom(m_axis_tdata);
            if (pending_geom.size() == 0) begin
                report("unexpected beat", 0, 1);
            end else begin
                want = pending_geom.pop_front();
                if (got.top_x !== want.top_x) report("top_x", want.top_x, got.top_x);
                if (got.top_y !== want.top_y) report("top_y", want.top_y, got.top_y);
                if (got.bot_x !== want.bot_x) report("bottom_x", want.bot_x, got.bot_x);
                if (got.bot_y !== want.bot_y) report("bottom_y", want.bot_y, got.bot_y);
                if (got.len !== want.len) report("bar_length", want.len, got.len);
                if (got.wid !== want.wid) report("bar_width", want.wid, got.wid);
                if (got.tilt !== want.tilt) report("tilt", want.tilt, got.tilt);
            end
        end
    end

    always @(negedge i_clk) m_axis_tready <= !do_idle();

    // watchdog: cycles with no accepted beat on either side
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    // push one box, expected geometry queued when the beat is accepted
    task automatic send_box(input t_box b, input bit has_exp, input t_geom fixed);
        t_geom g;
        while (do_idle()) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {b.ang, b.h, b.w, b.cy, b.cx};
        predict_geometry(b, g);
        if (has_exp) g = fixed;
        do @(posedge i_clk); while (!s_axis_tready);
        pending_geom.push_back(g);
        @(negedge i_clk);
    endtask

    function automatic t_box random_box();
        t_box b;
        int pick;
        b.cx = $urandom; b.cy = $urandom;
        pick = $urandom_range(9);
        // mostly realistic light-bar sizes, sometimes the full range
        if (pick < 6) begin
            b.w = $urandom_range(4095); b.h = $urandom_range(16383);
            b.cx = $urandom_range(40000, 2000); b.cy = $urandom_range(40000, 2000);
        end else begin
            b.w = $urandom; b.h = $urandom;
        end
        pick = $urandom_range(9);
        if (pick < 6) b.ang = 16'($signed($urandom_range(46080)) - 23040);
        else if (pick < 8) b.ang = 16'($urandom);
        else b.ang = 16'(256 * ($signed($urandom_range(360)) - 180));
        return b;
    endfunction

    function automatic t_row mk(int cx, int cy, int w, int h, int a);
        t_row r;
        r.box = '{16'(cx), 16'(cy), 16'(w), 16'(h), 16'(a)};
        r.has_exp = 0; r.exp_geom = '0;
        return r;
    endfunction

    initial begin
        t_row rows[$];
        t_row r;
        t_geom none;
        i_rst_n = 1'b0; s_axis_tvalid = 1'b0; s_axis_tdata = '0;
        none = '0;
        // zero size box: both points at the center, equal y, tilt 90
        r = mk(1600, 800, 0, 0, 0);
        r.has_exp = 1; r.exp_geom = '{18'sd1600, 18'sd800, 18'sd1600, 18'sd800, 0, 0, 15'd23040};
        rows.push_back(r);
        r = mk(0, 0, 0, 0, 23040);
        r.has_exp = 1; r.exp_geom = '{0, 0, 0, 0, 0, 0, 15'd23040};
        rows.push_back(r);
        rows.push_back(mk(1600, 1600, 160, 800, 0));
        rows.push_back(mk(1600, 1600, 160, 800, 23040));
        rows.push_back(mk(1600, 1600, 160, 800, -23040));
        rows.push_back(mk(1600, 1600, 160, 800, 11520));
        rows.push_back(mk(1600, 1600, 160, 800, -11520));
        rows.push_back(mk(1600, 1600, 160, 800, 23041));
        rows.push_back(mk(1600, 1600, 160, 800, -23041));
        rows.push_back(mk(1600, 1600, 160, 800, 32767));
        rows.push_back(mk(1600, 1600, 160, 800, -32768));
        rows.push_back(mk(1600, 1600, 160, 800, -1));
        rows.push_back(mk(65535, 65535, 65535, 65535, 0));      // bottom_y exceeds the 16-bit input range
        rows.push_back(mk(0, 0, 65535, 65535, 0));              // top goes negative
        rows.push_back(mk(0, 0, 65535, 65535, 11520));
        rows.push_back(mk(65535, 0, 65535, 65535, -5000));
        rows.push_back(mk(32768, 32768, 65535, 0, 23040));
        rows.push_back(mk(32768, 32768, 0, 65535, 0));
        rows.push_back(mk(43690, 21845, 21845, 43690, 21845));
        rows.push_back(mk(21845, 43690, 43690, 21845, -21846));
        rows.push_back(mk(12345, 23456, 1, 1, 100));
        rows.push_back(mk(500, 500, 65535, 65535, 30000));

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        fork
            begin
                foreach (rows[k]) send_box(rows[k].box, rows[k].has_exp, rows[k].exp_geom);
                for (int n = 0; n < RANDOM_BOXES; n++) begin
                    no_idle = (n >= 500 && n < 700);
                    send_box(random_box(), 0, none);
                end
                no_idle = 0;
                s_axis_tvalid <= 1'b0;
                while (pending_geom.size() != 0) @(negedge i_clk);
                repeat (DRAIN_CYCLES) @(negedge i_clk);
            end
            begin
                wait (idle_cycles >= WATCHDOG_LIMIT);
                timed_out = 1;
            end
        join_any
        disable fork;

        if (timed_out) begin
            $display("CHECK FAILED");
        end else if (mismatches == 0 && pending_geom.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule

FILE: filelist.f
design/lbag_pkg.sv
design/lbag_rot_stage.sv
design/lbag_vec_stage.sv
design/lbag_sqrt_stage.sv
design/light_bar_axis_geometry.sv
bench/tb_top.sv
